@@ sv/clce_pkg.sv @@
// shared types and codes for the circular list cursor engine
`timescale 1ns / 1ps

package clce_pkg;

  // payload widths fixed by the stream format
  localparam int KIND_BITS  = 3;
  localparam int VALUE_BITS = 32;

  typedef logic [KIND_BITS-1:0] kind_t;

  // operation codes carried in tuser
  localparam kind_t KIND_INS_BACK  = 3'd0;
  localparam kind_t KIND_INS_FRONT = 3'd1;
  localparam kind_t KIND_FIRST     = 3'd2;
  localparam kind_t KIND_NEXT      = 3'd3;
  localparam kind_t KIND_REMOVE    = 3'd4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOCUR = 2'd3
  } status_t;

  // result handed from the sequencer to the output register
  typedef struct packed {
    status_t                 status;
    logic [VALUE_BITS-1:0]   data;
  } res_t;

endpackage

@@ sv/circular_list_cursor_engine.sv @@
// top level of the circular list cursor engine: sequencer, node memory, output register
`timescale 1ns / 1ps

// Usage:
// in_*   : one item per operation; in_tuser is the operation kind (insert back,
//          insert front, cursor to first, cursor next, remove at cursor), in_tdata
//          the data word for inserts.
// out_*  : exactly one item per input item, in order: status, data word, node count.
// Results: rejected or unused kinds are answered from IDLE, list operations from
//          STEP2 (STEP1 for an insert into an empty list), through the output register.
// Flow: a new item is taken only in IDLE, after the last list operation has passed
//          its steps; rejected items never leave IDLE. The steps are set by the node link
//          memory: one registered read, then up to two write-backs through its single
//          write port.
// Reset: rst_n low for one clock empties the list and drops the cursor; node memory
//          is not cleared, every slot is written before it is ever read.
// Stall: one finished result waits in the output register while the next item is
//          accepted and worked; the engine holds its following result and stops
//          taking items until out_tready frees that register.

module circular_list_cursor_engine #(
  parameter int POOL_NODES = 64,
  parameter int DATA_BITS  = 32,
  localparam int IDX_W     = $clog2(POOL_NODES),
  localparam int CNT_W     = $clog2(POOL_NODES + 1),
  localparam int OUT_W     = ((CNT_W + 34 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // [31:0] value
  input  logic [2:0]        in_tuser,   // [2:0] kind
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata   // [1:0] status, [33:2] data_out, then count, zero pad
);

  import clce_pkg::*;

  // sequencer to result register
  logic             res_valid;
  logic             res_take;
  res_t             res;
  logic [CNT_W-1:0] res_count;

  // node memory ports
  logic [IDX_W-1:0]     lk_ra_addr, lk_ra_data;
  logic [IDX_W-1:0]     lk_rb_addr, lk_rb_data;
  logic                 lk_we;
  logic [IDX_W-1:0]     lk_waddr, lk_wdata;
  logic [IDX_W-1:0]     dt_raddr;
  logic [DATA_BITS-1:0] dt_rdata;
  logic                 dt_we;
  logic [IDX_W-1:0]     dt_waddr;
  logic [DATA_BITS-1:0] dt_wdata;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  clce_ctrl #(
    .NODES     (POOL_NODES),
    .DATA_BITS (DATA_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_value   (in_tdata),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .res_count  (res_count),
    .lk_ra_addr (lk_ra_addr),
    .lk_ra_data (lk_ra_data),
    .lk_rb_addr (lk_rb_addr),
    .lk_rb_data (lk_rb_data),
    .lk_we      (lk_we),
    .lk_waddr   (lk_waddr),
    .lk_wdata   (lk_wdata),
    .dt_raddr   (dt_raddr),
    .dt_rdata   (dt_rdata),
    .dt_we      (dt_we),
    .dt_waddr   (dt_waddr),
    .dt_wdata   (dt_wdata)
  );

  clce_node_mem #(
    .NODES     (POOL_NODES),
    .DATA_BITS (DATA_BITS)
  ) u_mem (
    .clk        (clk),
    .lk_ra_addr (lk_ra_addr),
    .lk_ra_data (lk_ra_data),
    .lk_rb_addr (lk_rb_addr),
    .lk_rb_data (lk_rb_data),
    .lk_we      (lk_we),
    .lk_waddr   (lk_waddr),
    .lk_wdata   (lk_wdata),
    .dt_raddr   (dt_raddr),
    .dt_rdata   (dt_rdata),
    .dt_we      (dt_we),
    .dt_waddr   (dt_waddr),
    .dt_wdata   (dt_wdata)
  );

  // the result register is free when empty or being drained this cycle
  assign res_take = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_W'({res_count, res.data, res.status});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ sv/clce_node_mem.sv @@
// node pool storage: link memory with two read ports, data memory with one
`timescale 1ns / 1ps

module clce_node_mem #(
  parameter int NODES     = 64,
  parameter int DATA_BITS = 32,
  localparam int IDX_W    = $clog2(NODES)
) (
  input  logic                 clk,
  input  logic [IDX_W-1:0]     lk_ra_addr,
  output logic [IDX_W-1:0]     lk_ra_data,
  input  logic [IDX_W-1:0]     lk_rb_addr,
  output logic [IDX_W-1:0]     lk_rb_data,
  input  logic                 lk_we,
  input  logic [IDX_W-1:0]     lk_waddr,
  input  logic [IDX_W-1:0]     lk_wdata,
  input  logic [IDX_W-1:0]     dt_raddr,
  output logic [DATA_BITS-1:0] dt_rdata,
  input  logic                 dt_we,
  input  logic [IDX_W-1:0]     dt_waddr,
  input  logic [DATA_BITS-1:0] dt_wdata
);

  logic [IDX_W-1:0]     link_mem [NODES];
  logic [DATA_BITS-1:0] data_mem [NODES];

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    lk_ra_data <= link_mem[lk_ra_addr];
    lk_rb_data <= link_mem[lk_rb_addr];
  end

  always_ff @(posedge clk) begin
    if (dt_we) begin
      data_mem[dt_waddr] <= dt_wdata;
    end
    dt_rdata <= data_mem[dt_raddr];
  end

endmodule

@@ sv/clce_ctrl.sv @@
// list sequencer: pointer registers and the read-modify-write steps on node memory
`timescale 1ns / 1ps

module clce_ctrl #(
  parameter int NODES     = 64,
  parameter int DATA_BITS = 32,
  localparam int IDX_W    = $clog2(NODES),
  localparam int CNT_W    = $clog2(NODES + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  clce_pkg::kind_t                    in_kind,
  input  logic [clce_pkg::VALUE_BITS-1:0]    in_value,
  output logic                               res_valid,
  input  logic                               res_take,
  output clce_pkg::res_t                     res,
  output logic [CNT_W-1:0]                   res_count,
  output logic [IDX_W-1:0]                   lk_ra_addr,
  input  logic [IDX_W-1:0]                   lk_ra_data,
  output logic [IDX_W-1:0]                   lk_rb_addr,
  input  logic [IDX_W-1:0]                   lk_rb_data,
  output logic                               lk_we,
  output logic [IDX_W-1:0]                   lk_waddr,
  output logic [IDX_W-1:0]                   lk_wdata,
  output logic [IDX_W-1:0]                   dt_raddr,
  input  logic [DATA_BITS-1:0]               dt_rdata,
  output logic                               dt_we,
  output logic [IDX_W-1:0]                   dt_waddr,
  output logic [DATA_BITS-1:0]               dt_wdata
);

  import clce_pkg::*;

  typedef enum logic [1:0] {IDLE, STEP1, STEP2} state_t;

  state_t                state_r, state_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [VALUE_BITS-1:0] value_r, value_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic                  list_ne_r, list_ne_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic [IDX_W-1:0]      prev_r, prev_nxt;
  logic                  cur_valid_r, cur_valid_nxt;
  logic                  rm_blk_r, rm_blk_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [CNT_W-1:0]      fresh_r, fresh_nxt;
  logic [IDX_W-1:0]      free_head_r, free_head_nxt;
  logic                  free_ne_r, free_ne_nxt;
  logic [IDX_W-1:0]      node_r, node_nxt;
  logic [IDX_W-1:0]      hold_r, hold_nxt;
  logic                  pend_r, pend_nxt;
  status_t               rs_status_r, rs_status_nxt;
  logic [VALUE_BITS-1:0] rs_data_r, rs_data_nxt;

  logic                  accept;
  logic [IDX_W-1:0]      new_slot;
  logic [DATA_BITS+VALUE_BITS-1:0] rd_ext;
  logic [DATA_BITS+VALUE_BITS-1:0] wr_ext;
  logic [VALUE_BITS-1:0] rd_word;

  // stored width may be narrower or wider than the stream word
  assign rd_ext  = {{VALUE_BITS{1'b0}}, dt_rdata};
  assign rd_word = rd_ext[VALUE_BITS-1:0];
  assign wr_ext  = {{DATA_BITS{1'b0}}, value_r};

  assign in_ready   = (state_r == IDLE) && (!pend_r || res_take);
  assign accept     = in_valid && in_ready;
  assign res_valid  = pend_r;
  assign res.status = rs_status_r;
  assign res.data   = rs_data_r;
  assign res_count  = total_r;

  assign new_slot = free_ne_r ? free_head_r : fresh_r[IDX_W-1:0];

  // port a always looks at the free chain head, port b at tail or cursor
  assign lk_ra_addr = free_head_r;
  assign lk_rb_addr = (in_kind == KIND_NEXT || in_kind == KIND_REMOVE) ? cur_r : tail_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    tail_nxt      = tail_r;
    list_ne_nxt   = list_ne_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    cur_valid_nxt = cur_valid_r;
    rm_blk_nxt    = rm_blk_r;
    total_nxt     = total_r;
    fresh_nxt     = fresh_r;
    free_head_nxt = free_head_r;
    free_ne_nxt   = free_ne_r;
    node_nxt      = node_r;
    hold_nxt      = hold_r;
    pend_nxt      = pend_r && !res_take;
    rs_status_nxt = rs_status_r;
    rs_data_nxt   = rs_data_r;
    lk_we         = 1'b0;
    lk_waddr      = node_r;
    lk_wdata      = hold_r;
    dt_we         = 1'b0;
    dt_waddr      = new_slot;
    dt_wdata      = wr_ext[DATA_BITS-1:0];
    dt_raddr      = (state_r == STEP1) ? lk_rb_data : cur_r;

    unique case (state_r)
      IDLE: begin
        if (accept) begin
          kind_nxt      = in_kind;
          value_nxt     = in_value;
          rs_status_nxt = ST_OK;
          rs_data_nxt   = '0;
          unique case (in_kind)
            KIND_INS_BACK, KIND_INS_FRONT: begin
              if (total_r == CNT_W'(NODES)) begin
                rs_status_nxt = ST_FULL;
                pend_nxt      = 1'b1;
              end else begin
                state_nxt = STEP1;
              end
            end
            KIND_FIRST: begin
              if (!list_ne_r) begin
                rs_status_nxt = ST_EMPTY;
                pend_nxt      = 1'b1;
              end else begin
                state_nxt = STEP1;
              end
            end
            KIND_NEXT: begin
              if (!list_ne_r) begin
                rs_status_nxt = ST_EMPTY;
                pend_nxt      = 1'b1;
              end else if (!cur_valid_r) begin
                rs_status_nxt = ST_NOCUR;
                pend_nxt      = 1'b1;
              end else begin
                state_nxt = STEP1;
              end
            end
            KIND_REMOVE: begin
              if (!list_ne_r) begin
                rs_status_nxt = ST_EMPTY;
                pend_nxt      = 1'b1;
              end else if (!cur_valid_r || rm_blk_r) begin
                rs_status_nxt = ST_NOCUR;
                pend_nxt      = 1'b1;
              end else begin
                state_nxt = STEP1;
              end
            end
            default: begin
              pend_nxt = 1'b1;
            end
          endcase
        end
      end

      STEP1: begin
        state_nxt = STEP2;
        unique case (kind_r)
          KIND_INS_BACK, KIND_INS_FRONT: begin
            // take a slot, store the data and link the new node forward
            if (free_ne_r) begin
              free_head_nxt = lk_ra_data;
              free_ne_nxt   = (fresh_r - total_r) > CNT_W'(1);
            end else begin
              fresh_nxt = fresh_r + CNT_W'(1);
            end
            dt_we     = 1'b1;
            lk_we     = 1'b1;
            lk_waddr  = new_slot;
            lk_wdata  = list_ne_r ? lk_rb_data : new_slot;
            total_nxt = total_r + CNT_W'(1);
            node_nxt  = new_slot;
            if (!list_ne_r) begin
              tail_nxt    = new_slot;
              list_ne_nxt = 1'b1;
              state_nxt   = IDLE;
              pend_nxt    = 1'b1;
            end
          end
          KIND_FIRST: begin
            prev_nxt      = tail_r;
            cur_nxt       = lk_rb_data;
            cur_valid_nxt = 1'b1;
            rm_blk_nxt    = 1'b0;
          end
          KIND_NEXT: begin
            prev_nxt   = cur_r;
            cur_nxt    = lk_rb_data;
            rm_blk_nxt = 1'b0;
          end
          KIND_REMOVE: begin
            // bypass the cursor node, then push it on the free chain next step
            rs_data_nxt = rd_word;
            rm_blk_nxt  = 1'b1;
            if (cur_r == tail_r) begin
              if (lk_rb_data == cur_r) begin
                list_ne_nxt   = 1'b0;
                cur_valid_nxt = 1'b0;
                rm_blk_nxt    = 1'b0;
              end else begin
                tail_nxt = prev_r;
              end
            end
            lk_we         = 1'b1;
            lk_waddr      = prev_r;
            lk_wdata      = lk_rb_data;
            cur_nxt       = prev_r;
            node_nxt      = cur_r;
            hold_nxt      = free_head_r;
            free_head_nxt = cur_r;
            free_ne_nxt   = 1'b1;
            total_nxt     = total_r - CNT_W'(1);
          end
          default: begin
            state_nxt = IDLE;
            pend_nxt  = 1'b1;
          end
        endcase
      end

      STEP2: begin
        state_nxt = IDLE;
        pend_nxt  = 1'b1;
        unique case (kind_r)
          KIND_INS_BACK, KIND_INS_FRONT: begin
            // close the ring: old tail now points at the new node
            lk_we    = 1'b1;
            lk_waddr = tail_r;
            lk_wdata = node_r;
            if (cur_valid_r && prev_r == tail_r) begin
              prev_nxt = node_r;
            end
            if (kind_r == KIND_INS_BACK) begin
              tail_nxt = node_r;
            end
          end
          KIND_FIRST, KIND_NEXT: begin
            rs_data_nxt = rd_word;
          end
          KIND_REMOVE: begin
            lk_we    = 1'b1;
            lk_waddr = node_r;
            lk_wdata = hold_r;
          end
          default: begin
            rs_data_nxt = '0;
          end
        endcase
      end

      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      tail_r      <= '0;
      list_ne_r   <= 1'b0;
      cur_r       <= '0;
      prev_r      <= '0;
      cur_valid_r <= 1'b0;
      rm_blk_r    <= 1'b0;
      total_r     <= '0;
      fresh_r     <= '0;
      free_head_r <= '0;
      free_ne_r   <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tail_r      <= tail_nxt;
      list_ne_r   <= list_ne_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      cur_valid_r <= cur_valid_nxt;
      rm_blk_r    <= rm_blk_nxt;
      total_r     <= total_nxt;
      fresh_r     <= fresh_nxt;
      free_head_r <= free_head_nxt;
      free_ne_r   <= free_ne_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    value_r     <= value_nxt;
    node_r      <= node_nxt;
    hold_r      <= hold_nxt;
    rs_status_r <= rs_status_nxt;
    rs_data_r   <= rs_data_nxt;
  end

endmodule
